// File: rtl/core/ephc_pkg.sv
// Package for the ELF64 program header checker: status codes, register
// indexes, format constants and the structs passed between the front and back.
// No dependencies.
package ephc_pkg;

    // Result status codes
    typedef enum logic [3:0] {
        ST_HDR_OK      = 4'd0,
        ST_SMALL       = 4'd1,
        ST_MAGIC       = 4'd2,
        ST_CLASS       = 4'd3,
        ST_ORDER       = 4'd4,
        ST_TYPE        = 4'd5,
        ST_MACHINE     = 4'd6,
        ST_ENTSIZE     = 4'd7,
        ST_TABLE_OUT   = 4'd8,
        ST_NO_HDR      = 4'd9,
        ST_ACCEPTED    = 4'd10,
        ST_SKIPPED     = 4'd11,
        ST_BEYOND_IMG  = 4'd12,
        ST_OUT_OF_USER = 4'd13,
        ST_TABLE_FULL  = 4'd14
    } t_status;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_SIZE = 2'd0,
        CFG_USER_LOW   = 2'd1,
        CFG_USER_HIGH  = 2'd2
    } t_cfg_idx;

    // Command codes
    localparam logic CMD_FILE_HDR = 1'b0;
    localparam logic CMD_PROG_HDR = 1'b1;

    // ELF format constants
    localparam logic [7:0]  ELF_MAG0        = 8'h7F;
    localparam logic [7:0]  ELF_MAG1        = 8'h45;  // 'E'
    localparam logic [7:0]  ELF_MAG2        = 8'h4C;  // 'L'
    localparam logic [7:0]  ELF_MAG3        = 8'h46;  // 'F'
    localparam logic [7:0]  ELF_CLASS_64BIT = 8'd2;
    localparam logic [7:0]  ELF_DATA_LSB    = 8'd1;
    localparam logic [31:0] ELF_ET_EXEC     = 32'd2;
    localparam logic [31:0] ELF_MACH_X86_64 = 32'd62;
    localparam logic [31:0] ELF_PT_LOAD     = 32'd1;
    localparam logic [23:0] HDR_MIN_BYTES   = 24'd64;
    localparam logic [15:0] PHDR_MIN_BYTES  = 16'd56;

    // Register reset values
    localparam logic [63:0] USER_LOW_RESET  = 64'h0000_0000_0040_0000;
    localparam logic [63:0] USER_HIGH_RESET = 64'h0000_0007_FFFF_F000;
    localparam logic [63:0] ALL_ONES        = 64'hFFFF_FFFF_FFFF_FFFF;

    // Configuration seen by the front
    typedef struct packed {
        logic [23:0] image_size;
        logic [63:0] user_low;
        logic [63:0] user_high;
    } t_cfg;

    // Classified request queued between front and back.
    // Header: code is the header status, addr_lo the entry point.
    // Program: code is the precheck (accepted, skipped, beyond, out of
    // user range), addr_lo/addr_hi the segment start and end.
    typedef struct packed {
        logic        is_hdr;
        logic        is_last;
        t_status     code;
        logic [63:0] addr_lo;
        logic [63:0] addr_hi;
    } t_fb_req;

    // Queue status
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

// File: rtl/core/ephc_if.sv
// Channel interfaces of the ELF64 program header checker: input records,
// results and configuration writes. Depends on nothing.
interface ephc_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [47:0] ident;
    logic [31:0] type_code;
    logic [31:0] machine_or_flags;
    logic [63:0] table_or_seg_offset;
    logic [63:0] entry_or_vaddr;
    logic [15:0] entry_count;
    logic [15:0] entry_size;
    logic [63:0] file_bytes;
    logic [63:0] mem_bytes;
    logic        is_last;

    modport source (
        output valid, command, ident, type_code, machine_or_flags,
               table_or_seg_offset, entry_or_vaddr, entry_count, entry_size,
               file_bytes, mem_bytes, is_last,
        input  ready
    );
    modport sink (
        input  valid, command, ident, type_code, machine_or_flags,
               table_or_seg_offset, entry_or_vaddr, entry_count, entry_size,
               file_bytes, mem_bytes, is_last,
        output ready
    );
endinterface

interface ephc_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic [3:0]  slot_index;
    logic [4:0]  accept_count;
    logic [63:0] span_low;
    logic [63:0] span_high;
    logic [63:0] start_pc;
    logic        parse_ok;

    modport source (
        output valid, status, slot_index, accept_count, span_low,
               span_high, start_pc, parse_ok,
        input  ready
    );
    modport sink (
        input  valid, status, slot_index, accept_count, span_low,
               span_high, start_pc, parse_ok,
        output ready
    );
endinterface

interface ephc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/ephc_front.sv
// Front of the checker: accepts records and classifies them against the
// configuration. Depends on ephc_pkg and ephc_in_if.
module ephc_front
    import ephc_pkg::*;
(
    ephc_in_if.sink  i_in,
    input  t_cfg     i_cfg,
    input  t_q_stat  i_q_stat,
    output logic     o_push,
    output t_fb_req  o_req
);

    logic [31:0] tbl_bytes;
    logic        off_over;
    logic [23:0] room;
    logic        tbl_over;
    logic        seg_over;
    logic [64:0] seg_sum;
    logic        addr_bad;
    t_status     hdr_code;
    t_status     prg_code;

    // Take a request whenever the queue has space
    assign i_in.ready = !i_q_stat.full;
    assign o_push     = i_in.valid && !i_q_stat.full;

    // Shared offset-in-image test; room is only meaningful when not over
    assign off_over = (i_in.table_or_seg_offset > {40'd0, i_cfg.image_size});
    assign room     = i_cfg.image_size - i_in.table_or_seg_offset[23:0];

    // Header table bounds
    assign tbl_bytes = i_in.entry_count * i_in.entry_size;
    assign tbl_over  = off_over || (tbl_bytes > {8'd0, room});

    // Segment bounds; carry out of the end address means wrap
    assign seg_over = off_over || (i_in.file_bytes > {40'd0, room});
    assign seg_sum  = {1'b0, i_in.entry_or_vaddr} + {1'b0, i_in.mem_bytes};
    assign addr_bad = seg_sum[64] || (i_in.entry_or_vaddr < i_cfg.user_low)
                      || (seg_sum[63:0] > i_cfg.user_high);

    // Header check, first failure wins
    always_comb begin
        priority if (i_cfg.image_size < HDR_MIN_BYTES) begin
            hdr_code = ST_SMALL;
        end else if (i_in.ident[7:0] != ELF_MAG0 || i_in.ident[15:8] != ELF_MAG1 ||
                     i_in.ident[23:16] != ELF_MAG2 ||
                     i_in.ident[31:24] != ELF_MAG3) begin
            hdr_code = ST_MAGIC;
        end else if (i_in.ident[39:32] != ELF_CLASS_64BIT) begin
            hdr_code = ST_CLASS;
        end else if (i_in.ident[47:40] != ELF_DATA_LSB) begin
            hdr_code = ST_ORDER;
        end else if (i_in.type_code != ELF_ET_EXEC) begin
            hdr_code = ST_TYPE;
        end else if (i_in.machine_or_flags != ELF_MACH_X86_64) begin
            hdr_code = ST_MACHINE;
        end else if (i_in.entry_size < PHDR_MIN_BYTES) begin
            hdr_code = ST_ENTSIZE;
        end else if (tbl_over) begin
            hdr_code = ST_TABLE_OUT;
        end else begin
            hdr_code = ST_HDR_OK;
        end
    end

    // Segment precheck; table-full and header state are resolved in the back
    always_comb begin
        priority if (i_in.type_code != ELF_PT_LOAD || i_in.mem_bytes == 64'd0) begin
            prg_code = ST_SKIPPED;
        end else if (seg_over) begin
            prg_code = ST_BEYOND_IMG;
        end else if (addr_bad) begin
            prg_code = ST_OUT_OF_USER;
        end else begin
            prg_code = ST_ACCEPTED;
        end
    end

    // Request to queue
    always_comb begin
        o_req.is_hdr  = (i_in.command == CMD_FILE_HDR);
        o_req.is_last = i_in.is_last;
        o_req.code    = (i_in.command == CMD_FILE_HDR) ? hdr_code : prg_code;
        o_req.addr_lo = i_in.entry_or_vaddr;
        o_req.addr_hi = seg_sum[63:0];
    end

endmodule

// File: rtl/core/ephc_fifo.sv
// Two-entry queue of classified requests between front and back.
// Depends on ephc_pkg.
module ephc_fifo
    import ephc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_fb_req  i_req,
    input  logic     i_pop,
    output t_fb_req  o_head,
    output t_q_stat  o_stat
);

    localparam int DEPTH = 2;

    t_fb_req     r_mem [DEPTH];
    logic        r_wr_ptr, n_wr_ptr;
    logic        r_rd_ptr, n_rd_ptr;
    logic [1:0]  r_count, n_count;

    // Pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = i_push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_pop  ? !r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.empty = (r_count == 2'd0);
    assign o_stat.full  = (r_count == 2'(DEPTH));

endmodule

// File: rtl/core/ephc_back.sv
// Back of the checker: holds the running segment state, resolves each queued
// request and registers the result. Depends on ephc_pkg and ephc_out_if.
module ephc_back
    import ephc_pkg::*;
#(
    parameter int MAX_SEGMENTS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_fb_req   i_head,
    input  t_q_stat   i_q_stat,
    output logic      o_pop,
    ephc_out_if.source o_out
);

    localparam int CW = $clog2(MAX_SEGMENTS + 1);

    // Running state
    logic          r_hdr_valid, n_hdr_valid;
    logic [CW-1:0] r_count, n_count;
    logic [63:0]   r_low, n_low;
    logic [63:0]   r_high, n_high;
    logic [63:0]   r_entry, n_entry;

    // Output register
    logic        r_out_valid;
    t_status     r_status, n_status;
    logic [3:0]  r_slot, n_slot;
    logic        r_parse, n_parse;

    logic            full;
    logic [CW+4:0]   slot_ext;
    logic [CW+4:0]   cnt_ext;

    assign o_pop   = !i_q_stat.empty && (!r_out_valid || o_out.ready);
    assign full    = (r_count >= CW'(MAX_SEGMENTS));
    assign slot_ext = {5'd0, r_count};
    assign cnt_ext  = {5'd0, r_count};

    // Resolve the head request against the state
    always_comb begin
        n_hdr_valid = r_hdr_valid;
        n_count     = r_count;
        n_low       = r_low;
        n_high      = r_high;
        n_entry     = r_entry;
        n_status    = i_head.code;
        n_slot      = 4'd0;
        n_parse     = 1'b0;
        if (i_head.is_hdr) begin
            n_count     = '0;
            n_low       = ALL_ONES;
            n_high      = 64'd0;
            n_hdr_valid = (i_head.code == ST_HDR_OK);
            n_entry     = (i_head.code == ST_HDR_OK) ? i_head.addr_lo : 64'd0;
        end else if (!r_hdr_valid) begin
            n_status = ST_NO_HDR;
        end else begin
            if (full) begin
                n_status = ST_TABLE_FULL;
            end else if (i_head.code == ST_ACCEPTED) begin
                n_slot  = slot_ext[3:0];
                n_count = r_count + CW'(1);
                if (i_head.addr_lo < r_low) begin
                    n_low = i_head.addr_lo;
                end
                if (i_head.addr_hi > r_high) begin
                    n_high = i_head.addr_hi;
                end
            end
            n_parse = i_head.is_last && (n_count != '0);
        end
    end

    // State update on each pop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_valid <= 1'b0;
            r_count     <= '0;
            r_low       <= ALL_ONES;
            r_high      <= 64'd0;
            r_entry     <= 64'd0;
        end else if (o_pop) begin
            r_hdr_valid <= n_hdr_valid;
            r_count     <= n_count;
            r_low       <= n_low;
            r_high      <= n_high;
            r_entry     <= n_entry;
        end
    end

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload; running fields come from the state registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_status <= n_status;
            r_slot   <= n_slot;
            r_parse  <= n_parse;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_status;
    assign o_out.slot_index   = r_slot;
    assign o_out.accept_count = cnt_ext[4:0];
    assign o_out.span_low     = r_low;
    assign o_out.span_high    = r_high;
    assign o_out.start_pc     = r_entry;
    assign o_out.parse_ok     = r_parse;

endmodule

// File: rtl/core/elf64_program_header_checker_core.sv
// ELF64 program header checker. One record (file header or program header)
// is accepted per cycle while the queue has space, and one result is returned
// per record, in order, after passing the two-entry classification queue and
// the back's output register. The sustained rate of one record per cycle holds
// while the result side does not stall and is set by the back, which updates
// its state on every pop. Configuration registers are written through the
// configuration channel, which is always ready. No clearing pass after reset.
module elf64_program_header_checker_core
    import ephc_pkg::*;
#(
    parameter int MAX_SEGMENTS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ephc_cfg_if.sink     i_cfg,
    ephc_in_if.sink      i_in,
    ephc_out_if.source   o_out
);

    logic [23:0] r_image_size;
    logic [63:0] r_user_low;
    logic [63:0] r_user_high;
    t_cfg        cfg;
    logic        push;
    logic        pop;
    t_fb_req     req;
    t_fb_req     head;
    t_q_stat     q_stat;

    // Configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_size <= 24'd0;
            r_user_low   <= USER_LOW_RESET;
            r_user_high  <= USER_HIGH_RESET;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_IMAGE_SIZE: r_image_size <= i_cfg.data[23:0];
                CFG_USER_LOW:   r_user_low   <= i_cfg.data;
                CFG_USER_HIGH:  r_user_high  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign cfg.image_size = r_image_size;
    assign cfg.user_low   = r_user_low;
    assign cfg.user_high  = r_user_high;

    // Front: accept and classify
    ephc_front u_front (
        .i_in     (i_in),
        .i_cfg    (cfg),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_req    (req)
    );

    // Queue
    ephc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (req),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    // Back: state and results
    ephc_back #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_out    (o_out)
    );

    // An accepted request is in the queue on the next cycle
    a_push_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !q_stat.empty)
        else $error("accepted request missing from queue");

    // An accepted segment leaves a nonempty, ordered address span
    a_accept_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status == ST_ACCEPTED) |->
        (o_out.accept_count != 5'd0 || MAX_SEGMENTS > 31) &&
        (o_out.span_low < o_out.span_high))
        else $error("accepted segment with bad span");

    // Without a valid header no entry point is held
    a_no_hdr_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status == ST_NO_HDR) |-> (o_out.start_pc == 64'd0))
        else $error("entry point held without valid header");

endmodule

// File: dv/tb_elf64_program_header_checker_core.sv
`timescale 1ns / 1ps
// Testbench for elf64_program_header_checker_core: directed and random ELF64 header and
// program-header requests, each result checked in order against an in-bench image checker.
// Depends on ephc_pkg, the ephc_*_if interfaces and the core RTL.
module tb_elf64_program_header_checker_core;
    import ephc_pkg::*;

    localparam int          MAX_SEGS      = 16;
    localparam int          CYCLE_LIMIT   = 500000;
    localparam int          SETTLE_CYCLES = 6;
    localparam logic [1:0]  CFG_IDX_SPARE = 2'd3;
    localparam logic [31:0] PT_NOTE       = 32'd4;
    localparam logic [31:0] ET_DYN        = 32'd3;
    localparam logic [31:0] EM_SPARC      = 32'd3;
    localparam logic [47:0] GOOD_IDENT    = {ELF_DATA_LSB, ELF_CLASS_64BIT,
                                             ELF_MAG3, ELF_MAG2, ELF_MAG1, ELF_MAG0};

    // One input request as it goes over the input channel
    typedef struct packed {
        logic        command;
        logic [47:0] ident;
        logic [31:0] type_code;
        logic [31:0] flags;
        logic [63:0] offset;
        logic [63:0] vaddr;
        logic [15:0] entry_count;
        logic [15:0] entry_size;
        logic [63:0] file_bytes;
        logic [63:0] mem_bytes;
        logic        is_last;
    } t_record;

    // Expected result of one request
    typedef struct packed {
        t_status     status;
        logic [3:0]  slot;
        logic [4:0]  count;
        logic [63:0] base;
        logic [63:0] top;
        logic [63:0] entry;
        logic        parse_ok;
    } t_verdict;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    ephc_in_if  in_ch ();
    ephc_out_if out_ch ();
    ephc_cfg_if cfg_ch ();

    elf64_program_header_checker_core #(
        .MAX_SEGMENTS(MAX_SEGS)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_ch),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    always #4 i_clk = ~i_clk;

    // Checker state, mirrors the block after reset
    logic [23:0] img_size   = '0;
    logic [63:0] win_low    = USER_LOW_RESET;
    logic [63:0] win_high   = USER_HIGH_RESET;
    logic        hdr_valid  = 1'b0;
    int          seg_count  = 0;
    logic [63:0] low_start  = ALL_ONES;
    logic [63:0] high_end   = '0;
    logic [63:0] entry_addr = '0;

    t_verdict verdict_q[$];
    int       err_count  = 0;
    int       cycle_cnt  = 0;
    int       stall_left = 0;
    logic     rx_steady  = 1'b0;
    logic     tx_steady  = 1'b0;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Uniform-ish value in [0, n), zero when n is zero
    function automatic logic [63:0] rand_below(logic [63:0] n);
        return (n == 0) ? 64'd0 : rand64() % n;
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 8);
        return $urandom_range(9, 40);
    endfunction

    // Classify one request and advance the running image state
    function automatic t_verdict predict_record(t_record r);
        t_verdict    v;
        logic [63:0] img;
        logic [63:0] tbl_bytes;
        logic [63:0] seg_end;
        img       = 64'(img_size);
        tbl_bytes = 64'(r.entry_count) * 64'(r.entry_size);
        seg_end   = r.vaddr + r.mem_bytes;
        v         = '0;
        v.status  = ST_HDR_OK;
        if (r.command == CMD_FILE_HDR) begin
            // first failing check wins
            if (img_size < HDR_MIN_BYTES)                      v.status = ST_SMALL;
            else if (r.ident[31:0] != GOOD_IDENT[31:0])        v.status = ST_MAGIC;
            else if (r.ident[39:32] != ELF_CLASS_64BIT)        v.status = ST_CLASS;
            else if (r.ident[47:40] != ELF_DATA_LSB)           v.status = ST_ORDER;
            else if (r.type_code != ELF_ET_EXEC)               v.status = ST_TYPE;
            else if (r.flags != ELF_MACH_X86_64)               v.status = ST_MACHINE;
            else if (r.entry_size < PHDR_MIN_BYTES)            v.status = ST_ENTSIZE;
            else if (r.offset > img || tbl_bytes > img - r.offset)
                v.status = ST_TABLE_OUT;
            seg_count  = 0;
            low_start  = ALL_ONES;
            high_end   = '0;
            hdr_valid  = (v.status == ST_HDR_OK);
            entry_addr = hdr_valid ? r.vaddr : 64'd0;
        end else if (!hdr_valid) begin
            v.status = ST_NO_HDR;
        end else begin
            if (seg_count >= MAX_SEGS)
                v.status = ST_TABLE_FULL;
            else if (r.type_code != ELF_PT_LOAD || r.mem_bytes == 0)
                v.status = ST_SKIPPED;
            else if (r.offset > img || r.file_bytes > img - r.offset)
                v.status = ST_BEYOND_IMG;
            else if (seg_end < r.vaddr || r.vaddr < win_low || seg_end > win_high)
                v.status = ST_OUT_OF_USER;
            else begin
                v.status  = ST_ACCEPTED;
                v.slot    = seg_count[3:0];
                seg_count = seg_count + 1;
                if (r.vaddr < low_start) low_start = r.vaddr;
                if (seg_end > high_end)  high_end  = seg_end;
            end
            v.parse_ok = r.is_last && (seg_count > 0);
        end
        v.count = seg_count[4:0];
        v.base  = low_start;
        v.top   = high_end;
        v.entry = entry_addr;
        return v;
    endfunction

    function automatic t_record file_header(logic [47:0] ident, logic [31:0] ftype,
                                            logic [31:0] mach, logic [63:0] tbl_off,
                                            logic [15:0] count, logic [15:0] size,
                                            logic [63:0] entry);
        t_record r;
        r.command     = CMD_FILE_HDR;
        r.ident       = ident;
        r.type_code   = ftype;
        r.flags       = mach;
        r.offset      = tbl_off;
        r.vaddr       = entry;
        r.entry_count = count;
        r.entry_size  = size;
        // fields the header ignores carry noise
        r.file_bytes  = rand64();
        r.mem_bytes   = rand64();
        r.is_last     = 1'($urandom_range(0, 1));
        return r;
    endfunction

    function automatic t_record program_header(logic [31:0] ptype, logic [63:0] off,
                                               logic [63:0] vaddr, logic [63:0] fsz,
                                               logic [63:0] msz, logic final_item);
        t_record r;
        r.command     = CMD_PROG_HDR;
        r.ident       = 48'(rand64());
        r.type_code   = ptype;
        r.flags       = $urandom;
        r.offset      = off;
        r.vaddr       = vaddr;
        r.entry_count = 16'($urandom);
        r.entry_size  = 16'($urandom);
        r.file_bytes  = fsz;
        r.mem_bytes   = msz;
        r.is_last     = final_item;
        return r;
    endfunction

    // Valid header whose table fits the current image
    function automatic t_record random_good_header();
        logic [63:0] img;
        logic [63:0] off;
        logic [63:0] room;
        logic [15:0] size;
        img  = 64'(img_size);
        size = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(56, 65535))
                                           : 16'($urandom_range(56, 120));
        off  = rand_below(img + 1);
        room = (img - off) / size;
        if (room > 65535) room = 65535;
        return file_header(GOOD_IDENT, ELF_ET_EXEC, ELF_MACH_X86_64, off,
                           16'(rand_below(room + 1)), size, rand64());
    endfunction

    // Valid header with one check altered; the new value may still pass
    function automatic t_record broken_header();
        t_record     r;
        logic [63:0] img;
        img = 64'(img_size);
        r   = random_good_header();
        case ($urandom_range(0, 7))
            0: r.ident[31:0] = r.ident[31:0] ^ (32'd1 << $urandom_range(0, 31));
            1: r.ident[39:32] = 8'($urandom);
            2: r.ident[47:40] = 8'($urandom);
            3: r.type_code = $urandom_range(0, 4);
            4: r.flags = $urandom_range(0, 1) ? EM_SPARC : $urandom;
            5: r.entry_size = 16'($urandom_range(0, 55));
            6: r.offset = img + 1 + rand_below(ALL_ONES - img);
            default: begin
                r.entry_count = 16'hFFFF;
                r.entry_size  = 16'hFFFF;
            end
        endcase
        return r;
    endfunction

    // Loadable segment inside the image and the user window (when there is one)
    function automatic t_record random_load_segment(logic final_item);
        logic [63:0] img;
        logic [63:0] off;
        logic [63:0] span;
        logic [63:0] msz;
        logic [63:0] lo;
        img  = 64'(img_size);
        off  = rand_below(img + 1);
        span = (win_high > win_low) ? win_high - win_low : 64'd0;
        if ($urandom_range(0, 3) == 0) msz = rand_below(span) + 1;
        else                           msz = rand_below((span < 65536) ? span : 65536) + 1;
        lo = win_low + rand_below(span - msz + 1);
        return program_header(ELF_PT_LOAD, off, lo, rand_below(img - off + 1), msz,
                              final_item);
    endfunction

    // Segment altered toward one rejection rule; the new value may still pass
    function automatic t_record broken_segment(logic final_item);
        t_record     r;
        logic [63:0] img;
        img = 64'(img_size);
        r   = random_load_segment(final_item);
        case ($urandom_range(0, 6))
            0: r.type_code = $urandom_range(0, 1) ? PT_NOTE : $urandom;
            1: r.mem_bytes = '0;
            2: r.offset = img + 1 + rand_below(ALL_ONES - img);
            3: r.file_bytes = img - r.offset + 1 + rand_below(256);
            4: begin
                r.vaddr     = ALL_ONES - rand_below(256);
                r.mem_bytes = rand_below(512) + 1;
            end
            5: r.vaddr = rand_below(win_low);
            default: begin
                r.vaddr     = win_high - rand_below(16);
                r.mem_bytes = rand_below(64) + 1;
            end
        endcase
        return r;
    endfunction

    function automatic t_record noise_record();
        t_record r;
        r.command     = 1'($urandom_range(0, 1));
        r.ident       = 48'(rand64());
        r.type_code   = $urandom;
        r.flags       = $urandom;
        r.offset      = rand64();
        r.vaddr       = rand64();
        r.entry_count = 16'($urandom);
        r.entry_size  = 16'($urandom);
        r.file_bytes  = rand64();
        r.mem_bytes   = rand64();
        r.is_last     = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 1)) r.type_code = r.command ? ELF_PT_LOAD : ELF_ET_EXEC;
        return r;
    endfunction

    // Send one request; the expectation is recorded at acceptance.
    // valid stays high so the next request can follow back to back.
    task automatic send_record(t_record r);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid               <= 1'b1;
        in_ch.command             <= r.command;
        in_ch.ident               <= r.ident;
        in_ch.type_code           <= r.type_code;
        in_ch.machine_or_flags    <= r.flags;
        in_ch.table_or_seg_offset <= r.offset;
        in_ch.entry_or_vaddr      <= r.vaddr;
        in_ch.entry_count         <= r.entry_count;
        in_ch.entry_size          <= r.entry_size;
        in_ch.file_bytes          <= r.file_bytes;
        in_ch.mem_bytes           <= r.mem_bytes;
        in_ch.is_last             <= r.is_last;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        verdict_q.push_back(predict_record(r));
    endtask

    // Stop sending and wait until every result is back
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write, only with the block idle
    task automatic write_reg(logic [1:0] idx, logic [63:0] value);
        drain_results();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (cfg_ch.ready !== 1'b1) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_IMAGE_SIZE: img_size = value[23:0];
            CFG_USER_LOW:   win_low  = value;
            CFG_USER_HIGH:  win_high = value;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic configure_image(logic [23:0] img, logic [63:0] lo, logic [63:0] hi);
        write_reg(CFG_IMAGE_SIZE, 64'(img));
        write_reg(CFG_USER_LOW, lo);
        write_reg(CFG_USER_HIGH, hi);
    endtask

    // One header followed by a run of program headers
    task automatic send_random_image(int seg_total);
        int   roll;
        logic final_item;
        roll = $urandom_range(0, 99);
        if (roll < 75)      send_record(random_good_header());
        else if (roll < 92) send_record(broken_header());
        else                send_record(noise_record());
        for (int i = 0; i < seg_total; i++) begin
            final_item = (i == seg_total - 1) || ($urandom_range(0, 19) == 0);
            roll       = $urandom_range(0, 99);
            if (roll < 75)      send_record(random_load_segment(final_item));
            else if (roll < 93) send_record(broken_segment(final_item));
            else                send_record(noise_record());
        end
    endtask

    // After reset: zero image size and no header yet
    task automatic test_reset_state();
        send_record(file_header(GOOD_IDENT, ELF_ET_EXEC, ELF_MACH_X86_64, 64'd64,
                                16'd0, 16'd56, rand64()));
        send_record(program_header(ELF_PT_LOAD, 64'd0, USER_LOW_RESET, 64'd0, 64'h1000,
                                   1'b1));
    endtask

    // Each header rule in order, at the smallest legal image
    task automatic test_header_checks();
        t_record hdr;
        t_record r;
        write_reg(CFG_IDX_SPARE, ALL_ONES);  // unused index, must be ignored
        configure_image(24'd64, USER_LOW_RESET, USER_HIGH_RESET);
        hdr = file_header(GOOD_IDENT, ELF_ET_EXEC, ELF_MACH_X86_64, 64'd8, 16'd1,
                          16'd56, rand64());
        for (int b = 0; b < 4; b++) begin
            r       = hdr;
            r.ident = GOOD_IDENT ^ (48'h80 << (8 * b));
            send_record(r);
        end
        r = hdr; r.ident[39:32] = 8'd1;        send_record(r);
        r = hdr; r.ident[47:40] = 8'd2;        send_record(r);
        r = hdr; r.type_code = ET_DYN;         send_record(r);
        r = hdr; r.flags = EM_SPARC;           send_record(r);
        r = hdr; r.entry_size = 16'd55;        send_record(r);
        r = hdr; r.offset = 64'd65;            send_record(r);
        r = hdr; r.offset = 64'd9;             send_record(r);
        r = hdr; r.offset = ALL_ONES;          send_record(r);
        // largest table size product
        r = hdr; r.offset = 64'd0; r.entry_count = 16'hFFFF; r.entry_size = 16'hFFFF;
        send_record(r);
        send_record(hdr);  // table ends exactly at the image end
    endtask

    // Segment rules under the reset user window, image of 64 bytes
    task automatic test_segment_checks();
        send_record(file_header(GOOD_IDENT, ELF_ET_EXEC, ELF_MACH_X86_64, 64'd0,
                                16'd0, 16'd56, rand64()));
        send_record(program_header(PT_NOTE, 64'd0, USER_LOW_RESET, 64'd0, 64'd16, 1'b0));
        send_record(program_header(ELF_PT_LOAD, 64'd0, USER_LOW_RESET, 64'd0, 64'd0, 1'b0));
        send_record(program_header(ELF_PT_LOAD, 64'd65, USER_LOW_RESET, 64'd0, 64'd16,
                                   1'b0));
        send_record(program_header(ELF_PT_LOAD, 64'd8, USER_LOW_RESET, 64'd57, 64'd16,
                                   1'b0));
        // start plus size wraps past the top of the address space
        send_record(program_header(ELF_PT_LOAD, 64'd0, ALL_ONES, 64'd0, 64'd2, 1'b0));
        send_record(program_header(ELF_PT_LOAD, 64'd0, USER_LOW_RESET - 1, 64'd0, 64'd16,
                                   1'b0));
        send_record(program_header(ELF_PT_LOAD, 64'd0, USER_HIGH_RESET - 64'h10, 64'd0,
                                   64'h11, 1'b0));
        // exactly the whole window and an empty file part at the image end
        send_record(program_header(ELF_PT_LOAD, 64'd64, USER_LOW_RESET, 64'd0,
                                   USER_HIGH_RESET - USER_LOW_RESET, 1'b0));
        send_record(program_header(ELF_PT_LOAD, 64'd0, 64'h50_0000, 64'd64, 64'h1000,
                                   1'b1));
        // a bad header drops the table
        send_record(file_header(GOOD_IDENT, ET_DYN, ELF_MACH_X86_64, 64'd0, 16'd0,
                                16'd56, rand64()));
        send_record(program_header(ELF_PT_LOAD, 64'd0, 64'h50_0000, 64'd0, 64'h10, 1'b1));
    endtask

    // Fill the segment table past its capacity, then start over
    task automatic test_table_full();
        configure_image(24'h80_0000, 64'h1000, 64'h1_0000_0000);
        send_record(random_good_header());
        for (int i = 0; i < MAX_SEGS + 4; i++)
            send_record(random_load_segment(i == MAX_SEGS + 3));
        send_record(random_good_header());
        send_record(random_load_segment(1'b1));
    endtask

    // Random images under several register settings, extremes included
    task automatic test_random_traffic(int items_per_phase);
        logic [63:0] lo_addr;
        int          sent;
        int          roll;
        int          seg_total;
        for (int phase = 0; phase < 6; phase++) begin
            lo_addr = rand64();
            case (phase)
                0: configure_image(24'h80_0000, 64'd0, ALL_ONES);
                1: configure_image(24'd4096, USER_LOW_RESET, USER_HIGH_RESET);
                2: configure_image(24'($urandom_range(64, 8388608)), ALL_ONES, ALL_ONES);
                3: configure_image(24'($urandom_range(64, 8388608)), lo_addr, 64'd0);
                4: configure_image(24'($urandom_range(64, 8388608)), lo_addr,
                                   lo_addr + rand_below(ALL_ONES - lo_addr));
                default: configure_image(24'd200, rand_below(64'h1_0000),
                                         ALL_ONES - rand_below(64'h1_0000));
            endcase
            sent = 0;
            while (sent < items_per_phase) begin
                if ($urandom_range(0, 9) == 0) tx_steady = !tx_steady;
                if ($urandom_range(0, 29) == 0) drain_results();
                roll      = $urandom_range(0, 99);
                seg_total = (roll < 8)  ? 0 :
                            (roll < 94) ? $urandom_range(1, 8) : $urandom_range(16, 20);
                send_random_image(seg_total);
                sent = sent + seg_total + 1;
            end
        end
    endtask

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            err_count++;
        end
    endfunction

    // Result side: compare each result with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_verdict want;
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: result with no request outstanding, status %0d", $time,
                         out_ch.status);
                err_count++;
            end else begin
                want = verdict_q.pop_front();
                check_field("status", 64'(want.status), 64'(out_ch.status));
                check_field("slot_index", 64'(want.slot), 64'(out_ch.slot_index));
                check_field("accept_count", 64'(want.count), 64'(out_ch.accept_count));
                check_field("span_low", want.base, out_ch.span_low);
                check_field("span_high", want.top, out_ch.span_high);
                check_field("start_pc", want.entry, out_ch.start_pc);
                check_field("parse_ok", 64'(want.parse_ok), 64'(out_ch.parse_ok));
            end
        end
    end

    // Result side back-pressure, with stretches of constant readiness
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 199) == 0) rx_steady <= !rx_steady;
            stall_left <= rx_steady ? 0 : pick_gap();
        end
    end

    // Run-away guard
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, verdict_q.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        in_ch.valid               = 1'b0;
        in_ch.command             = CMD_FILE_HDR;
        in_ch.ident               = '0;
        in_ch.type_code           = '0;
        in_ch.machine_or_flags    = '0;
        in_ch.table_or_seg_offset = '0;
        in_ch.entry_or_vaddr      = '0;
        in_ch.entry_count         = '0;
        in_ch.entry_size          = '0;
        in_ch.file_bytes          = '0;
        in_ch.mem_bytes           = '0;
        in_ch.is_last             = 1'b0;
        cfg_ch.valid              = 1'b0;
        cfg_ch.index              = CFG_IMAGE_SIZE;
        cfg_ch.data               = '0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_header_checks();
        test_segment_checks();
        test_table_full();
        test_random_traffic(110);

        drain_results();
        if (err_count == 0) $display("All tests passed");
        else                $display("Some tests failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/ephc_pkg.sv
rtl/core/ephc_if.sv
rtl/core/ephc_front.sv
rtl/core/ephc_fifo.sv
rtl/core/ephc_back.sv
rtl/core/elf64_program_header_checker_core.sv
dv/tb_elf64_program_header_checker_core.sv
